### hdl/ipv4_forward_decision_lpm_assert.svh
// Assertion macros for the forwarding block checkers.
`ifndef IPV4_FORWARD_DECISION_LPM_ASSERT_SVH
`define IPV4_FORWARD_DECISION_LPM_ASSERT_SVH

// Check that a condition implies another in the same cycle.
`define IPFWD_ASSERT_IMP(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |-> (c)) \
        else $error("ipfwd: same-cycle check failed");

// Check that a condition implies another in the next cycle.
`define IPFWD_ASSERT_NXT(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |=> (c)) \
        else $error("ipfwd: next-cycle check failed");

`endif

### hdl/ipfwd_pkg.sv
`default_nettype none

package ipfwd_pkg;

    localparam logic [1:0] MODE_ROUTE    = 2'd0;
    localparam logic [1:0] MODE_IFACE    = 2'd1;
    localparam logic [1:0] MODE_CLASSIFY = 2'd2;

    localparam logic [2:0] ACT_LOAD          = 3'd0;
    localparam logic [2:0] ACT_FORWARD       = 3'd1;
    localparam logic [2:0] ACT_ECHO          = 3'd2;
    localparam logic [2:0] ACT_PORT_UNREACH  = 3'd3;
    localparam logic [2:0] ACT_TIME_EXCEEDED = 3'd4;
    localparam logic [2:0] ACT_HOST_UNREACH  = 3'd5;
    localparam logic [2:0] ACT_DROP          = 3'd6;

    localparam logic [7:0] ICMP_PROTO        = 8'd1;
    localparam logic [7:0] ECHO_REQUEST_TYPE = 8'd8;
    localparam logic [7:0] ECHO_REQUEST_CODE = 8'd0;
    localparam logic [7:0] TTL_MIN           = 8'd1;

    typedef struct packed {
        logic [31:0] dest;
        logic [31:0] mask;
        logic [31:0] gateway;
        logic [1:0]  port;
    } route_t;

    typedef struct packed {
        logic hit;
        logic better;
    } cmp_res_t;

endpackage

`default_nettype wire

### hdl/ipfwd_cmp.sv
`default_nettype none

module ipfwd_cmp (
    input  wire logic [31:0]       a,
    input  wire logic [31:0]       b,
    input  wire logic [31:0]       mask,
    input  wire logic [31:0]       best_mask,
    input  wire logic              has_best,
    output ipfwd_pkg::cmp_res_t    res
);

    always_comb begin
        res.hit    = (((a ^ b) & mask) == 32'd0);
        res.better = !has_best || (mask > best_mask);
    end

endmodule

`default_nettype wire

### hdl/ipv4_forward_decision_lpm.sv
`default_nettype none

// IPv4 forwarding decision with longest-prefix route lookup. Every item gives exactly one
// result. Load items (mode 0 route, mode 1 interface, mode 3 no-op) are accepted, written in
// the accept cycle and answered via ST_RESP into the output register. A classify item walks
// the interface table and then the route table through one shared masked comparator, one
// entry per cycle: a local destination or a TTL of 1 or less is answered after the interface
// walk, a full route lookup after ST_PRIME and the route walk, an order set by that comparator
// and the single registered read port of the route memory. The block takes no new item until
// its result has moved into the output register; that register holds the result until the
// sink takes it. Tables are empty after reset with no clearing pass: per-entry valid flops
// gate every lookup.
module ipv4_forward_decision_lpm #(
    parameter int ROUTE_ENTRIES   = 16,
    parameter int INTERFACE_COUNT = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_mode,
    input  wire logic [3:0]  s_slot,
    input  wire logic [31:0] s_entry_addr,
    input  wire logic [31:0] s_entry_mask,
    input  wire logic [31:0] s_entry_gateway,
    input  wire logic [1:0]  s_entry_port,
    input  wire logic        s_entry_valid,
    input  wire logic [31:0] s_pkt_dst,
    input  wire logic [7:0]  s_pkt_ttl,
    input  wire logic [7:0]  s_pkt_proto,
    input  wire logic [7:0]  s_icmp_kind,
    input  wire logic [7:0]  s_icmp_sub,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_action,
    output logic [1:0]       m_out_port,
    output logic [31:0]      m_next_hop,
    output logic [7:0]       m_new_ttl,
    output logic [3:0]       m_route_index
);

    localparam int RIDX_W = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
    localparam int IIDX_W = (INTERFACE_COUNT > 1) ? $clog2(INTERFACE_COUNT) : 1;
    localparam logic [RIDX_W-1:0] RIDX_LAST = RIDX_W'(ROUTE_ENTRIES - 1);
    localparam logic [IIDX_W-1:0] IIDX_LAST = IIDX_W'(INTERFACE_COUNT - 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOCAL = 3'd1;
    localparam logic [2:0] ST_PRIME = 3'd2;
    localparam logic [2:0] ST_ROUTE = 3'd3;
    localparam logic [2:0] ST_RESP  = 3'd4;

    ipfwd_pkg::route_t route_mem [ROUTE_ENTRIES];
    ipfwd_pkg::route_t rd_word_reg;
    logic [RIDX_W-1:0] raddr;

    logic [ROUTE_ENTRIES-1:0]   route_valid_reg;
    logic [31:0]                if_ip_reg [INTERFACE_COUNT];
    logic [INTERFACE_COUNT-1:0] if_valid_reg;

    logic [2:0]        state_reg, state_next;
    logic [31:0]       dst_reg, dst_next;
    logic [7:0]        ttl_reg, ttl_next;
    logic [7:0]        proto_reg, proto_next;
    logic [7:0]        kind_reg, kind_next;
    logic [7:0]        sub_reg, sub_next;
    logic              local_reg, local_next;
    logic [IIDX_W-1:0] if_idx_reg, if_idx_next;
    logic [RIDX_W-1:0] rt_idx_reg, rt_idx_next;
    logic              has_best_reg, has_best_next;
    logic [31:0]       best_mask_reg, best_mask_next;
    logic [31:0]       best_gw_reg, best_gw_next;
    logic [1:0]        best_port_reg, best_port_next;
    logic [RIDX_W-1:0] best_idx_reg, best_idx_next;
    logic [2:0]        act_reg, act_next;

    logic              m_valid_reg, m_valid_next;
    logic [2:0]        m_action_reg, m_action_next;
    logic [1:0]        m_port_reg, m_port_next;
    logic [31:0]       m_hop_reg, m_hop_next;
    logic [7:0]        m_ttl_reg, m_ttl_next;
    logic [3:0]        m_ridx_reg, m_ridx_next;

    logic [31:0]          cmp_a, cmp_mask;
    ipfwd_pkg::cmp_res_t  cmp_res;
    logic                 accept;
    logic                 local_now;
    logic                 take;
    logic                 fwd;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    ipfwd_cmp u_cmp (
        .a         (cmp_a),
        .b         (dst_reg),
        .mask      (cmp_mask),
        .best_mask (best_mask_reg),
        .has_best  (has_best_reg),
        .res       (cmp_res)
    );

    always_comb begin
        if (state_reg == ST_ROUTE) begin
            cmp_a    = rd_word_reg.dest;
            cmp_mask = rd_word_reg.mask;
        end else begin
            cmp_a    = if_ip_reg[if_idx_reg];
            cmp_mask = '1;
        end
    end

    always_comb begin
        if (state_reg == ST_ROUTE && rt_idx_reg != RIDX_LAST) begin
            raddr = rt_idx_reg + 1'b1;
        end else begin
            raddr = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && s_mode == ipfwd_pkg::MODE_ROUTE && 32'(s_slot) < ROUTE_ENTRIES) begin
            route_mem[RIDX_W'(s_slot)] <= '{dest: s_entry_addr, mask: s_entry_mask,
                                            gateway: s_entry_gateway, port: s_entry_port};
        end
        rd_word_reg <= route_mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (accept && s_mode == ipfwd_pkg::MODE_IFACE && 32'(s_slot) < INTERFACE_COUNT) begin
            if_ip_reg[IIDX_W'(s_slot)] <= s_entry_addr;
        end
    end

    always_comb begin
        state_next     = state_reg;
        dst_next       = dst_reg;
        ttl_next       = ttl_reg;
        proto_next     = proto_reg;
        kind_next      = kind_reg;
        sub_next       = sub_reg;
        local_next     = local_reg;
        if_idx_next    = if_idx_reg;
        rt_idx_next    = rt_idx_reg;
        has_best_next  = has_best_reg;
        best_mask_next = best_mask_reg;
        best_gw_next   = best_gw_reg;
        best_port_next = best_port_reg;
        best_idx_next  = best_idx_reg;
        act_next       = act_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_action_next  = m_action_reg;
        m_port_next    = m_port_reg;
        m_hop_next     = m_hop_reg;
        m_ttl_next     = m_ttl_reg;
        m_ridx_next    = m_ridx_reg;
        local_now      = local_reg || (cmp_res.hit && if_valid_reg[if_idx_reg]);
        take           = route_valid_reg[rt_idx_reg] && cmp_res.hit && cmp_res.better;
        fwd            = (act_reg == ipfwd_pkg::ACT_FORWARD);

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    has_best_next = 1'b0;
                    if (s_mode == ipfwd_pkg::MODE_CLASSIFY) begin
                        dst_next    = s_pkt_dst;
                        ttl_next    = s_pkt_ttl;
                        proto_next  = s_pkt_proto;
                        kind_next   = s_icmp_kind;
                        sub_next    = s_icmp_sub;
                        local_next  = 1'b0;
                        if_idx_next = '0;
                        state_next  = ST_LOCAL;
                    end else begin
                        act_next   = ipfwd_pkg::ACT_LOAD;
                        state_next = ST_RESP;
                    end
                end
            end
            ST_LOCAL: begin
                local_next  = local_now;
                if_idx_next = if_idx_reg + 1'b1;
                if (if_idx_reg == IIDX_LAST) begin
                    state_next = ST_RESP;
                    if (local_now) begin
                        if (proto_reg != ipfwd_pkg::ICMP_PROTO) begin
                            act_next = ipfwd_pkg::ACT_PORT_UNREACH;
                        end else if (kind_reg == ipfwd_pkg::ECHO_REQUEST_TYPE &&
                                     sub_reg == ipfwd_pkg::ECHO_REQUEST_CODE) begin
                            act_next = ipfwd_pkg::ACT_ECHO;
                        end else begin
                            act_next = ipfwd_pkg::ACT_DROP;
                        end
                    end else if (ttl_reg <= ipfwd_pkg::TTL_MIN) begin
                        act_next = ipfwd_pkg::ACT_TIME_EXCEEDED;
                    end else begin
                        state_next = ST_PRIME;
                    end
                end
            end
            ST_PRIME: begin
                rt_idx_next = '0;
                state_next  = ST_ROUTE;
            end
            ST_ROUTE: begin
                if (take) begin
                    has_best_next  = 1'b1;
                    best_mask_next = rd_word_reg.mask;
                    best_gw_next   = rd_word_reg.gateway;
                    best_port_next = rd_word_reg.port;
                    best_idx_next  = rt_idx_reg;
                end
                rt_idx_next = rt_idx_reg + 1'b1;
                if (rt_idx_reg == RIDX_LAST) begin
                    act_next   = (take || has_best_reg) ? ipfwd_pkg::ACT_FORWARD
                                                        : ipfwd_pkg::ACT_HOST_UNREACH;
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_action_next = act_reg;
                    m_port_next   = fwd ? best_port_reg : 2'd0;
                    m_hop_next    = fwd ? best_gw_reg : 32'd0;
                    m_ttl_next    = fwd ? (ttl_reg - 8'd1) : 8'd0;
                    m_ridx_next   = fwd ? 4'(best_idx_reg) : 4'd0;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            m_valid_reg     <= 1'b0;
            route_valid_reg <= '0;
            if_valid_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (accept && s_mode == ipfwd_pkg::MODE_ROUTE &&
                32'(s_slot) < ROUTE_ENTRIES) begin
                route_valid_reg[RIDX_W'(s_slot)] <= s_entry_valid;
            end
            if (accept && s_mode == ipfwd_pkg::MODE_IFACE &&
                32'(s_slot) < INTERFACE_COUNT) begin
                if_valid_reg[IIDX_W'(s_slot)] <= s_entry_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        dst_reg       <= dst_next;
        ttl_reg       <= ttl_next;
        proto_reg     <= proto_next;
        kind_reg      <= kind_next;
        sub_reg       <= sub_next;
        local_reg     <= local_next;
        if_idx_reg    <= if_idx_next;
        rt_idx_reg    <= rt_idx_next;
        has_best_reg  <= has_best_next;
        best_mask_reg <= best_mask_next;
        best_gw_reg   <= best_gw_next;
        best_port_reg <= best_port_next;
        best_idx_reg  <= best_idx_next;
        act_reg       <= act_next;
        m_action_reg  <= m_action_next;
        m_port_reg    <= m_port_next;
        m_hop_reg     <= m_hop_next;
        m_ttl_reg     <= m_ttl_next;
        m_ridx_reg    <= m_ridx_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_action      = m_action_reg;
    assign m_out_port    = m_port_reg;
    assign m_next_hop    = m_hop_reg;
    assign m_new_ttl     = m_ttl_reg;
    assign m_route_index = m_ridx_reg;

endmodule

`default_nettype wire

### hdl/ipfwd_checker.sv
`default_nettype none

`include "ipv4_forward_decision_lpm_assert.svh"

module ipfwd_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [2:0]  m_action,
    input wire logic [1:0]  m_out_port,
    input wire logic [31:0] m_next_hop,
    input wire logic [7:0]  m_new_ttl,
    input wire logic [3:0]  m_route_index
);

    `IPFWD_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_action) && $stable(m_next_hop) && $stable(m_route_index))

    `IPFWD_ASSERT_IMP(a_idle_fields, aclk, aresetn,
        m_valid && m_action != ipfwd_pkg::ACT_FORWARD,
        m_out_port == 2'd0 && m_next_hop == 32'd0 && m_new_ttl == 8'd0 &&
        m_route_index == 4'd0)

    `IPFWD_ASSERT_IMP(a_fwd_ttl, aclk, aresetn,
        m_valid && m_action == ipfwd_pkg::ACT_FORWARD, m_new_ttl != 8'd0)

    `IPFWD_ASSERT_NXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)

endmodule

bind ipv4_forward_decision_lpm ipfwd_checker u_ipfwd_checker (.*);

`default_nettype wire

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int N_ROUTE = 16;
    localparam int N_IFACE = 4;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        logic [1:0]  mode;
        logic [3:0]  slot;
        logic [31:0] addr;
        logic [31:0] mask;
        logic [31:0] gw;
        logic [1:0]  port;
        logic        ena;
        logic [31:0] dst;
        logic [7:0]  ttl;
        logic [7:0]  proto;
        logic [7:0]  kind;
        logic [7:0]  sub;
    } fwd_item_t;

    typedef struct {
        logic [2:0]  action;
        logic [1:0]  port;
        logic [31:0] hop;
        logic [7:0]  ttl;
        logic [3:0]  idx;
    } fwd_decision_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_mode = '0;
    logic [3:0]  s_slot = '0;
    logic [31:0] s_entry_addr = '0;
    logic [31:0] s_entry_mask = '0;
    logic [31:0] s_entry_gateway = '0;
    logic [1:0]  s_entry_port = '0;
    logic        s_entry_valid = 1'b0;
    logic [31:0] s_pkt_dst = '0;
    logic [7:0]  s_pkt_ttl = '0;
    logic [7:0]  s_pkt_proto = '0;
    logic [7:0]  s_icmp_kind = '0;
    logic [7:0]  s_icmp_sub = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_action;
    logic [1:0]  m_out_port;
    logic [31:0] m_next_hop;
    logic [7:0]  m_new_ttl;
    logic [3:0]  m_route_index;

    logic [31:0] rt_dest [N_ROUTE] = '{default: '0};
    logic [31:0] rt_mask [N_ROUTE] = '{default: '0};
    logic [31:0] rt_gw   [N_ROUTE] = '{default: '0};
    logic [1:0]  rt_port [N_ROUTE] = '{default: '0};
    logic        rt_ok   [N_ROUTE] = '{default: '0};
    logic [31:0] if_addr [N_IFACE] = '{default: '0};
    logic        if_ok   [N_IFACE] = '{default: '0};

    fwd_decision_t pending_decisions[$];
    fwd_decision_t want;

    int idle_pct = 0;
    int stall_pct = 0;
    int hold_req = 0;
    int hold_left = 0;
    int idle_cycles = 0;
    int errors = 0;
    int items_sent = 0;
    int directed_sent = 0;
    int results_seen = 0;
    int act_seen [8] = '{default: 0};

    ipv4_forward_decision_lpm #(
        .ROUTE_ENTRIES   (N_ROUTE),
        .INTERFACE_COUNT (N_IFACE)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_slot          (s_slot),
        .s_entry_addr    (s_entry_addr),
        .s_entry_mask    (s_entry_mask),
        .s_entry_gateway (s_entry_gateway),
        .s_entry_port    (s_entry_port),
        .s_entry_valid   (s_entry_valid),
        .s_pkt_dst       (s_pkt_dst),
        .s_pkt_ttl       (s_pkt_ttl),
        .s_pkt_proto     (s_pkt_proto),
        .s_icmp_kind     (s_icmp_kind),
        .s_icmp_sub      (s_icmp_sub),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_action        (m_action),
        .m_out_port      (m_out_port),
        .m_next_hop      (m_next_hop),
        .m_new_ttl       (m_new_ttl),
        .m_route_index   (m_route_index)
    );

    always #5 aclk = ~aclk;

    function automatic fwd_decision_t forward_decision(input fwd_item_t it);
        fwd_decision_t d;
        bit local_hit;
        int best;
        logic [31:0] best_mask;
        d = '{action: ipfwd_pkg::ACT_LOAD, port: '0, hop: '0, ttl: '0, idx: '0};
        local_hit = 1'b0;
        best = -1;
        best_mask = '0;
        case (it.mode)
            ipfwd_pkg::MODE_ROUTE: begin
                rt_dest[it.slot] = it.addr;
                rt_mask[it.slot] = it.mask;
                rt_gw[it.slot]   = it.gw;
                rt_port[it.slot] = it.port;
                rt_ok[it.slot]   = it.ena;
            end
            ipfwd_pkg::MODE_IFACE: begin
                if (it.slot < N_IFACE) begin
                    if_addr[it.slot] = it.addr;
                    if_ok[it.slot]   = it.ena;
                end
            end
            ipfwd_pkg::MODE_CLASSIFY: begin
                foreach (if_addr[k])
                    if (if_ok[k] && if_addr[k] == it.dst)
                        local_hit = 1'b1;
                if (local_hit) begin
                    if (it.proto != ipfwd_pkg::ICMP_PROTO)
                        d.action = ipfwd_pkg::ACT_PORT_UNREACH;
                    else if (it.kind == ipfwd_pkg::ECHO_REQUEST_TYPE &&
                             it.sub == ipfwd_pkg::ECHO_REQUEST_CODE)
                        d.action = ipfwd_pkg::ACT_ECHO;
                    else
                        d.action = ipfwd_pkg::ACT_DROP;
                end else if (it.ttl <= ipfwd_pkg::TTL_MIN) begin
                    d.action = ipfwd_pkg::ACT_TIME_EXCEEDED;
                end else begin
                    foreach (rt_dest[k]) begin
                        if (rt_ok[k] && (rt_dest[k] & rt_mask[k]) == (it.dst & rt_mask[k])
                                && (best < 0 || rt_mask[k] > best_mask)) begin
                            best = k;
                            best_mask = rt_mask[k];
                        end
                    end
                    if (best < 0) begin
                        d.action = ipfwd_pkg::ACT_HOST_UNREACH;
                    end else begin
                        d.action = ipfwd_pkg::ACT_FORWARD;
                        d.port   = rt_port[best];
                        d.hop    = rt_gw[best];
                        d.ttl    = it.ttl - 8'd1;
                        d.idx    = 4'(best);
                    end
                end
            end
            default: ;
        endcase
        return d;
    endfunction

    function automatic fwd_item_t rand_item();
        fwd_item_t it;
        it.mode  = 2'($urandom);
        it.slot  = 4'($urandom);
        it.addr  = $urandom;
        it.mask  = $urandom;
        it.gw    = $urandom;
        it.port  = 2'($urandom);
        it.ena   = 1'($urandom);
        it.dst   = $urandom;
        it.ttl   = 8'($urandom);
        it.proto = 8'($urandom);
        it.kind  = 8'($urandom);
        it.sub   = 8'($urandom);
        return it;
    endfunction

    function automatic logic [31:0] net_pick();
        logic [7:0] top;
        case ($urandom_range(3))
            0: top = 8'd10;
            1: top = 8'd192;
            2: top = 8'd172;
            default: top = 8'($urandom);
        endcase
        return {top, 8'($urandom_range(0, 2)), 8'($urandom_range(0, 2)), 8'($urandom)};
    endfunction

    function automatic fwd_item_t mk_route(input logic [3:0] slot, input logic [31:0] dest,
                                           input logic [31:0] mask, input logic [31:0] gw,
                                           input logic [1:0] port, input logic ena);
        fwd_item_t it;
        it = rand_item();
        it.mode = ipfwd_pkg::MODE_ROUTE;
        it.slot = slot;
        it.addr = dest;
        it.mask = mask;
        it.gw   = gw;
        it.port = port;
        it.ena  = ena;
        return it;
    endfunction

    function automatic fwd_item_t mk_iface(input logic [3:0] slot, input logic [31:0] addr,
                                           input logic ena);
        fwd_item_t it;
        it = rand_item();
        it.mode = ipfwd_pkg::MODE_IFACE;
        it.slot = slot;
        it.addr = addr;
        it.ena  = ena;
        return it;
    endfunction

    function automatic fwd_item_t mk_pkt(input logic [31:0] dst, input logic [7:0] ttl,
                                         input logic [7:0] proto, input logic [7:0] kind,
                                         input logic [7:0] sub);
        fwd_item_t it;
        it = rand_item();
        it.mode  = ipfwd_pkg::MODE_CLASSIFY;
        it.dst   = dst;
        it.ttl   = ttl;
        it.proto = proto;
        it.kind  = kind;
        it.sub   = sub;
        return it;
    endfunction

    function automatic fwd_item_t rand_route();
        int plen;
        logic [31:0] mask;
        plen = ($urandom_range(3) == 0) ? $urandom_range(0, 32) : 8 * $urandom_range(0, 4);
        mask = (plen == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - plen));
        return mk_route(4'($urandom), net_pick(), mask, $urandom, 2'($urandom),
                        $urandom_range(6) != 0);
    endfunction

    function automatic fwd_item_t rand_iface();
        logic [3:0] slot;
        logic [31:0] addr;
        slot = ($urandom_range(4) == 0) ? 4'($urandom) : 4'($urandom_range(0, N_IFACE - 1));
        addr = $urandom_range(1) ? net_pick() : rt_dest[$urandom_range(0, N_ROUTE - 1)];
        return mk_iface(slot, addr, $urandom_range(5) != 0);
    endfunction

    function automatic fwd_item_t rand_packet();
        int r;
        logic [31:0] dst;
        logic [7:0] ttl;
        r = $urandom_range(0, N_ROUTE - 1);
        case ($urandom_range(3))
            0: dst = if_addr[$urandom_range(0, N_IFACE - 1)];
            1, 2: dst = (rt_dest[r] & rt_mask[r]) | ($urandom & ~rt_mask[r]);
            default: dst = $urandom_range(1) ? net_pick() : $urandom;
        endcase
        case ($urandom_range(9))
            0: ttl = 8'd0;
            1: ttl = 8'd1;
            default: ttl = 8'($urandom_range(2, 255));
        endcase
        return mk_pkt(dst, ttl,
                      $urandom_range(1) ? ipfwd_pkg::ICMP_PROTO : 8'($urandom),
                      ($urandom_range(4) < 3) ? ipfwd_pkg::ECHO_REQUEST_TYPE : 8'($urandom),
                      ($urandom_range(4) < 3) ? ipfwd_pkg::ECHO_REQUEST_CODE : 8'($urandom));
    endfunction

    task automatic send_item(input fwd_item_t it);
        @(negedge aclk);
        while ($urandom_range(99) < idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_mode          = it.mode;
        s_slot          = it.slot;
        s_entry_addr    = it.addr;
        s_entry_mask    = it.mask;
        s_entry_gateway = it.gw;
        s_entry_port    = it.port;
        s_entry_valid   = it.ena;
        s_pkt_dst       = it.dst;
        s_pkt_ttl       = it.ttl;
        s_pkt_proto     = it.proto;
        s_icmp_kind     = it.kind;
        s_icmp_sub      = it.sub;
        s_valid         = 1'b1;
        do @(posedge aclk); while (!s_ready);
        pending_decisions.push_back(forward_decision(it));
        items_sent++;
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_decisions.size() != 0)
            @(posedge aclk);
    endtask

    task automatic test_directed();
        fwd_item_t it;
        idle_pct  = 0;
        stall_pct = 0;
        send_item(mk_route(4'd0, 32'h0, 32'h0, 32'hFFFF_FFFF, 2'd3, 1'b1));
        send_item(mk_route(4'd15, 32'hC0A8_0100, 32'hFFFF_FF00, 32'h0A0A_0A01, 2'd1, 1'b1));
        send_item(mk_route(4'd5, 32'hC0A8_01FF, 32'hFFFF_FF00, 32'h0102_0304, 2'd2, 1'b1));
        send_item(mk_route(4'd7, 32'hC0A8_0142, 32'hFFFF_FFFF, 32'h0, 2'd0, 1'b1));
        send_item(mk_route(4'd9, 32'h0A00_0000, 32'hFF00_0000, 32'h0B0B_0B0B, 2'd2, 1'b0));
        send_item(mk_iface(4'd0, 32'hC0A8_0101, 1'b1));
        send_item(mk_iface(4'd3, 32'hFFFF_FFFF, 1'b1));
        send_item(mk_iface(4'd9, 32'h0A00_0001, 1'b1));
        it = '{mode: MODE_UNUSED, slot: '1, addr: '1, mask: '1, gw: '1, port: '1, ena: 1'b1,
               dst: '1, ttl: '1, proto: '1, kind: '1, sub: '1};
        send_item(it);
        send_item(mk_pkt(32'hC0A8_0101, 8'd64, ipfwd_pkg::ICMP_PROTO,
                         ipfwd_pkg::ECHO_REQUEST_TYPE, ipfwd_pkg::ECHO_REQUEST_CODE));
        send_item(mk_pkt(32'hC0A8_0101, 8'd64, ipfwd_pkg::ICMP_PROTO,
                         ipfwd_pkg::ECHO_REQUEST_TYPE, 8'd1));
        send_item(mk_pkt(32'hC0A8_0101, 8'd64, ipfwd_pkg::ICMP_PROTO, 8'd0, 8'd0));
        send_item(mk_pkt(32'hC0A8_0101, 8'd0, 8'd6, ipfwd_pkg::ECHO_REQUEST_TYPE, 8'd0));
        send_item(mk_pkt(32'hFFFF_FFFF, 8'd1, 8'd17, 8'd255, 8'd255));
        send_item(mk_pkt(32'h0A00_0001, 8'd0, ipfwd_pkg::ICMP_PROTO,
                         ipfwd_pkg::ECHO_REQUEST_TYPE, 8'd0));
        send_item(mk_pkt(32'h0A00_0001, 8'd1, 8'd6, 8'd3, 8'd3));
        send_item(mk_pkt(32'h0A00_0001, 8'd2, 8'd6, 8'd0, 8'd0));
        send_item(mk_pkt(32'hC0A8_0177, 8'd255, 8'd17, 8'd0, 8'd0));
        send_item(mk_pkt(32'hC0A8_0142, 8'd64, ipfwd_pkg::ICMP_PROTO,
                         ipfwd_pkg::ECHO_REQUEST_TYPE, 8'd0));
        send_item(mk_route(4'd0, 32'h0, 32'h0, 32'h0, 2'd0, 1'b0));
        send_item(mk_pkt(32'h0A00_0001, 8'd200, 8'd6, 8'd0, 8'd0));
        send_item(mk_iface(4'd0, 32'hC0A8_0101, 1'b0));
        send_item(mk_pkt(32'hC0A8_0101, 8'd9, ipfwd_pkg::ICMP_PROTO,
                         ipfwd_pkg::ECHO_REQUEST_TYPE, 8'd0));
        send_item(mk_pkt(32'h0, 8'd2, 8'd0, 8'd0, 8'd0));
        drain();
        directed_sent = items_sent;
    endtask

    task automatic test_traffic(input int n, input int idle, input int stall);
        int sent;
        idle_pct  = idle;
        stall_pct = stall;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(9) == 0) begin
                send_item(rand_item());
                sent++;
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    send_item(rand_route());
                    sent++;
                end
                if ($urandom_range(2) == 0) begin
                    send_item(rand_iface());
                    sent++;
                end
                repeat ($urandom_range(3, 12)) begin
                    send_item(rand_packet());
                    sent++;
                end
            end
        end
        drain();
    endtask

    task automatic test_backpressure();
        idle_pct  = 0;
        stall_pct = 0;
        hold_req  = HOLD_CYCLES;
        repeat (24)
            send_item(($urandom_range(3) == 0) ? rand_route() : rand_packet());
        drain();
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(negedge aclk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            act_seen[m_action]++;
            if (pending_decisions.size() == 0) begin
                $error("unexpected result: action %0d", m_action);
                errors++;
            end else begin
                want = pending_decisions.pop_front();
                check_field("action", want.action, m_action);
                check_field("out_port", want.port, m_out_port);
                check_field("next_hop", want.hop, m_next_hop);
                check_field("new_ttl", want.ttl, m_new_ttl);
                check_field("route_index", want.idx, m_route_index);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no handshake for %0d cycles, %0d results outstanding",
                     idle_cycles, pending_decisions.size());
            $display("** ipv4_forward_decision_lpm: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_directed();
        test_traffic(500, 0, 0);
        test_traffic(300, 80, 0);
        test_traffic(300, 0, 80);
        test_backpressure();
        test_traffic(400, 13, 13);
        repeat (40) @(posedge aclk);
        $display("Run: %0d items (%0d directed), %0d results checked across free-run, %s",
                 items_sent, directed_sent, results_seen,
                 "sender gaps, sink stalls, mixed idling and a long sink hold-off.");
        $display("Actions: load %0d fwd %0d echo %0d port-unr %0d ttl-exc %0d host-unr %0d drop %0d",
                 act_seen[ipfwd_pkg::ACT_LOAD], act_seen[ipfwd_pkg::ACT_FORWARD],
                 act_seen[ipfwd_pkg::ACT_ECHO], act_seen[ipfwd_pkg::ACT_PORT_UNREACH],
                 act_seen[ipfwd_pkg::ACT_TIME_EXCEEDED], act_seen[ipfwd_pkg::ACT_HOST_UNREACH],
                 act_seen[ipfwd_pkg::ACT_DROP]);
        if (errors == 0 && pending_decisions.size() == 0) begin
            $display("** ipv4_forward_decision_lpm: PASSED **");
        end else begin
            $display("** ipv4_forward_decision_lpm: FAILED **");
        end
        $finish;
    end

endmodule
